// ===== design/blvf_pkg.sv =====
// shared types and constants for the brass lip valve filter
`default_nettype none

package blvf_pkg;

  // register formats
  localparam int COEF_W = 18;
  localparam int GAIN_W = 16;
  localparam int CFG_W = 18;
  localparam int CFG_IDX_W = 2;

  // shared multiplier: operand a carries coefficients, gain, lip opening and square input
  localparam int MUL_A_W = 25;
  localparam int SQ_W = 24;
  localparam int T_W = 17;
  localparam int POLE_SHIFT = 16;
  localparam int SQ_SHIFT = 32;
  localparam int STATE_INT_BITS = 8;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  localparam logic signed [COEF_W-1:0] FB_ONE_RESET = 18'sd0;
  localparam logic signed [COEF_W-1:0] FB_TWO_RESET = -18'sd65144;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1966;

  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_MUL_POLE1,
    ST_MUL_POLE2,
    ST_ADD_POLE2,
    ST_SAT,
    ST_MUL_SQUARE,
    ST_MUL_MIX,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_GAIN,
    MUL_POLE1,
    MUL_POLE2,
    MUL_SQUARE,
    MUL_MIX
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     in_load;
    logic     acc_load;
    logic     acc_add;
    logic     sat_en;
    logic     out_load;
    logic     prod_hold;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/blvf_ctrl.sv =====
// sequencer for the lip valve datapath and the handshakes on both channels
`default_nettype none

module blvf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output blvf_pkg::cmd_t     cmd
);
  import blvf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.mul_sel   = MUL_GAIN;
    cmd.in_load   = 1'b0;
    cmd.acc_load  = 1'b0;
    cmd.acc_add   = 1'b0;
    cmd.sat_en    = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.prod_hold = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = ST_MUL_GAIN;
        end
      end
      ST_MUL_GAIN: begin
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = ST_MUL_POLE1;
      end
      ST_MUL_POLE1: begin
        cmd.mul_sel  = MUL_POLE1;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_MUL_POLE2;
      end
      ST_MUL_POLE2: begin
        cmd.mul_sel = MUL_POLE2;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_ADD_POLE2;
      end
      ST_ADD_POLE2: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat_en = 1'b1;
        state_nxt  = ST_MUL_SQUARE;
      end
      ST_MUL_SQUARE: begin
        cmd.mul_sel = MUL_SQUARE;
        state_nxt   = ST_MUL_MIX;
      end
      ST_MUL_MIX: begin
        cmd.mul_sel = MUL_MIX;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // mixed product waits in the product register until the output is free
        cmd.prod_hold = 1'b1;
        // result goes to the output register once it is free; next beat may enter alongside
        if (out_free) begin
          cmd.out_load = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.in_load = 1'b1;
            state_nxt   = ST_MUL_GAIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/blvf_datapath.sv =====
// configuration registers, resonator state, shared multiplier and output register
`default_nettype none

module blvf_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int STATE_BITS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire blvf_pkg::cmd_t                    cmd,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_mouth_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_bore_sample,
  input  wire logic                              cfg_we,
  input  wire logic [blvf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [blvf_pkg::CFG_W-1:0]        cfg_data,
  output logic signed [SAMPLE_BITS-1:0]          out_lip_output
);
  import blvf_pkg::*;

  localparam int MB0   = (STATE_BITS > SAMPLE_BITS + 1) ? STATE_BITS : SAMPLE_BITS + 1;
  localparam int MB    = (MB0 > SQ_W + 1) ? MB0 : SQ_W + 1;
  localparam int PW    = MUL_A_W + MB;
  localparam int ACC_W = STATE_BITS + 3;
  localparam int SF    = STATE_BITS - STATE_INT_BITS;
  localparam int SH    = SF - GAIN_W - (SAMPLE_BITS - 1);
  localparam int SHL   = (SH >= 0) ? SH : 0;
  localparam int SHR   = (SH < 0) ? -SH : 0;
  localparam int YSL   = (SF < SQ_W) ? SQ_W - SF : 0;
  localparam int YSR   = (SF > SQ_W) ? SF - SQ_W : 0;
  localparam int YW    = STATE_BITS + 8;

  localparam logic [STATE_BITS-1:0] SMAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic [STATE_BITS-1:0] SMIN = {1'b1, {(STATE_BITS-1){1'b0}}};

  logic signed [COEF_W-1:0]       fb_one_r, fb_two_r;
  logic [GAIN_W-1:0]              gain_r;
  logic signed [SAMPLE_BITS-1:0]  bore_r;
  logic signed [SAMPLE_BITS:0]    diff_r;
  logic signed [STATE_BITS-1:0]   y1_r, y2_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [PW-1:0]           prod_r;
  logic [SQ_W-1:0]                ys_r;
  logic                           ge1_r;
  logic signed [SAMPLE_BITS-1:0]  out_r;

  logic signed [MUL_A_W-1:0]      op_a;
  logic signed [MB-1:0]           op_b;
  logic signed [PW-1:0]           mul_p;
  logic [T_W-1:0]                 t_val;
  logic signed [PW-1:0]           gain_al;
  logic signed [ACC_W-1:0]        gain_term, pole_term;
  logic [ACC_W-STATE_BITS:0]      acc_hi;
  logic                           acc_ovf;
  logic signed [STATE_BITS-1:0]   y_sat;
  logic [STATE_BITS-1:0]          mag;
  logic                           ge1;
  logic [YW-1:0]                  ys_wide;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_one_r <= FB_ONE_RESET;
      fb_two_r <= FB_TWO_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FEEDBACK_ONE: fb_one_r <= cfg_data;
        CFG_FEEDBACK_TWO: fb_two_r <= cfg_data;
        CFG_INPUT_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // lip opening: clamped to one, else top bits of the square
  assign t_val = ge1_r ? T_ONE : T_W'(prod_r[SQ_SHIFT +: GAIN_W]);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_GAIN: begin
        op_a = MUL_A_W'(gain_r);
        op_b = MB'(diff_r);
      end
      MUL_POLE1: begin
        op_a = MUL_A_W'(fb_one_r);
        op_b = MB'(y1_r);
      end
      MUL_POLE2: begin
        op_a = MUL_A_W'(fb_two_r);
        op_b = MB'(y2_r);
      end
      MUL_SQUARE: begin
        op_a = MUL_A_W'(ys_r);
        op_b = MB'(ys_r);
      end
      MUL_MIX: begin
        op_a = MUL_A_W'(t_val);
        op_b = MB'(diff_r);
      end
      default: begin
        op_a = MUL_A_W'(gain_r);
        op_b = MB'(diff_r);
      end
    endcase
  end

  assign mul_p = op_a * op_b;

  // drive aligned to the state format, pole products floored by 2^16
  assign gain_al   = (prod_r <<< SHL) >>> SHR;
  assign gain_term = ACC_W'(gain_al);
  assign pole_term = ACC_W'(prod_r >>> POLE_SHIFT);

  // saturation to the state range
  assign acc_hi  = acc_r[ACC_W-1:STATE_BITS-1];
  assign acc_ovf = !((&acc_hi) || !(|acc_hi));
  assign y_sat   = acc_ovf ? (acc_r[ACC_W-1] ? SMIN : SMAX) : acc_r[STATE_BITS-1:0];

  assign mag     = y_sat[STATE_BITS-1] ? (~y_sat + 1'b1) : y_sat;
  assign ge1     = |mag[STATE_BITS-1:SF];
  assign ys_wide = (YW'(mag) << YSL) >> YSR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_r <= '0;
      y2_r <= '0;
    end else if (cmd.sat_en) begin
      y1_r <= y_sat;
      y2_r <= y1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.prod_hold) begin
      prod_r <= mul_p;
    end
    if (cmd.in_load) begin
      bore_r <= in_bore_sample;
      diff_r <= (SAMPLE_BITS+1)'(in_mouth_sample) - (SAMPLE_BITS+1)'(in_bore_sample);
    end
    if (cmd.acc_load) begin
      acc_r <= gain_term;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + pole_term;
    end
    if (cmd.sat_en) begin
      ys_r  <= ys_wide[SQ_W-1:0];
      ge1_r <= ge1;
    end
    if (cmd.out_load) begin
      out_r <= bore_r + prod_r[POLE_SHIFT +: SAMPLE_BITS];
    end
  end

  assign out_lip_output = out_r;

endmodule

`default_nettype wire

// ===== design/brass_lip_valve_filter_core.sv =====
// top level of the brass lip valve filter
`default_nettype none

// Lip valve of a brass player: each input beat carries a mouth and a bore pressure sample;
// their difference, scaled by input_gain, drives a saturating two-pole resonator whose
// squared output, clamped to one, opens the lip and mixes the two samples into one output
// beat. One 25 x max(STATE_BITS, SAMPLE_BITS+1, 25) bit multiplier is shared through five
// products per beat (gain, two poles, square, mix), so no new beat is taken until the
// previous result is written to the output register; a new beat is accepted in the same
// cycle the previous result is written. Configuration writes take effect at once and
// belong in idle periods.

module brass_lip_valve_filter_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int STATE_BITS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_mouth_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_bore_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]          out_lip_output,
  input  wire logic                              cfg_we,
  input  wire logic [blvf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [blvf_pkg::CFG_W-1:0]        cfg_data
);
  import blvf_pkg::*;

  cmd_t cmd;

  blvf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  blvf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mouth_sample (in_mouth_sample),
    .in_bore_sample  (in_bore_sample),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_lip_output  (out_lip_output)
  );

  // busy after a beat is taken in
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while the previous beat is still in work");

  // a result is written into a free output register only
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result written over an output beat not yet taken");

  // once the sequence after acceptance reaches ST_DONE the result is written or waits behind a held output
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##8 (cmd.out_load || out_valid))
    else $error("result not ready on schedule");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the brass lip valve filter core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blvf_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W = 32;
  localparam int STATE_FRAC = STATE_W - STATE_INT_BITS;
  localparam int GAIN_SHIFT = GAIN_W + SAMPLE_W - 1 - STATE_FRAC;
  localparam int T_FRAC = 16;
  localparam longint STATE_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN = -STATE_MAX - 1;
  localparam longint MAG_ONE = longint'(1) <<< STATE_FRAC;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 12;
  localparam int PHASE_BEATS = 160;
  localparam int MAX_PRINTED = 50;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_mouth_sample;
  logic signed [SAMPLE_W-1:0] in_bore_sample;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] out_lip_output;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // predictor copy of the registers and the resonator history
  logic signed [COEF_W-1:0] fb_one;
  logic signed [COEF_W-1:0] fb_two;
  logic [GAIN_W-1:0] gain;
  longint res_y1;
  longint res_y2;

  logic signed [SAMPLE_W-1:0] lip_expected[$];

  int cycles = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int writes_done = 0;
  int gap_max = 9;
  int stall_max = 9;
  int hold_asked = 0;

  always #1 clk = ~clk;

  brass_lip_valve_filter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mouth_sample(in_mouth_sample),
    .in_bore_sample (in_bore_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lip_output (out_lip_output),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  function automatic logic signed [SAMPLE_W-1:0] lip_step(
    input logic signed [SAMPLE_W-1:0] mouth,
    input logic signed [SAMPLE_W-1:0] bore
  );
    longint d;
    longint y;
    longint mag;
    longint t;
    longint mix;
    d = longint'(mouth) - longint'(bore);
    // arithmetic shifts of signed products round toward minus infinity
    y = ((longint'(gain) * d) >>> GAIN_SHIFT)
        + ((longint'(fb_one) * res_y1) >>> POLE_SHIFT)
        + ((longint'(fb_two) * res_y2) >>> POLE_SHIFT);
    if (y > STATE_MAX) y = STATE_MAX;
    if (y < STATE_MIN) y = STATE_MIN;
    res_y2 = res_y1;
    res_y1 = y;
    mag = (y < 0) ? -y : y;
    // with 24 fraction bits in the state the magnitude squares as it stands
    if (mag >= MAG_ONE) t = longint'(T_ONE);
    else t = (mag * mag) >>> SQ_SHIFT;
    mix = longint'(bore) + ((t * d) >>> T_FRAC);
    return mix[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] small_sample();
    return SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic send_pressures(input logic signed [SAMPLE_W-1:0] mouth,
                                input logic signed [SAMPLE_W-1:0] bore);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mouth_sample <= mouth;
    in_bore_sample <= bore;
    do @(posedge clk); while (in_ready !== 1'b1);
    lip_expected.push_back(lip_step(mouth, bore));
    beats_sent++;
  endtask

  // block drained and quiet: safe point for register writes
  task automatic settle();
    in_valid <= 1'b0;
    while (lip_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FEEDBACK_ONE: fb_one = data[COEF_W-1:0];
      CFG_FEEDBACK_TWO: fb_two = data[COEF_W-1:0];
      CFG_INPUT_GAIN:   gain = data[GAIN_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // result side: random stalls, long hold-off on request, checks every beat
  initial begin : result_side
    int stall_left;
    int hold_left;
    int hold_seen;
    logic took;
    logic signed [SAMPLE_W-1:0] want;
    stall_left = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      took = (rst_n && out_valid && out_ready) === 1'b1;
      if (took) begin
        results_seen++;
        if (lip_expected.size() == 0) begin
          report_mismatch($sformatf("lip_output %0d with no beat pending", out_lip_output));
        end else begin
          want = lip_expected.pop_front();
          if (out_lip_output !== want)
            report_mismatch($sformatf("lip_output result %0d: got %0d, expected %0d",
                                      results_seen, out_lip_output, want));
        end
      end
      if (hold_left == 0 && hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (took) begin
        stall_left = $urandom_range(0, stall_max);
        out_ready <= (stall_left == 0);
      end else if (!out_ready) begin
        if (stall_left > 0) stall_left--;
        out_ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_reset_extremes();
    gap_max = 9;
    stall_max = 9;
    send_pressures(S_MAX, S_MIN);
    send_pressures(S_MIN, S_MAX);
    send_pressures(16'sd0, 16'sd0);
    send_pressures(S_MAX, S_MAX);
    send_pressures(S_MIN, S_MIN);
    send_pressures(16'sd1, -16'sd1);
    send_pressures(-16'sd1, 16'sd0);
    send_pressures(16'sd16384, -16'sd16384);
  endtask

  task automatic test_register_extremes();
    int i;
    settle();
    // explosive poles with full gain: state saturates, lip fully open
    write_setting(CFG_FEEDBACK_ONE, 18'h1ffff);
    write_setting(CFG_FEEDBACK_TWO, 18'h1ffff);
    write_setting(CFG_INPUT_GAIN, 18'h3ffff);
    for (i = 0; i < 5; i++) send_pressures(i[0] ? S_MIN : S_MAX, i[0] ? S_MAX : S_MIN);
    settle();
    // most negative poles, gain zero with stray upper data bits, unused index
    write_setting(CFG_FEEDBACK_ONE, 18'h20000);
    write_setting(CFG_FEEDBACK_TWO, 18'h20000);
    write_setting(CFG_INPUT_GAIN, 18'h30000);
    write_setting(CFG_UNUSED, 18'h2aaaa);
    for (i = 0; i < 5; i++) send_pressures(small_sample(), SAMPLE_W'($urandom));
    settle();
    // no feedback: opening follows the drive alone, partly open
    write_setting(CFG_FEEDBACK_ONE, 18'h00000);
    write_setting(CFG_FEEDBACK_TWO, 18'h00000);
    write_setting(CFG_INPUT_GAIN, 18'h0ffff);
    send_pressures(16'sd1000, 16'sd0);
    send_pressures(16'sd0, 16'sd1000);
    send_pressures(S_MAX, S_MIN);
    send_pressures(16'sd256, -16'sd256);
    send_pressures(-16'sd5, 16'sd3);
  endtask

  task automatic test_output_hold_off();
    int i;
    settle();
    gap_max = 0;
    hold_asked <= hold_asked + 1;
    for (i = 0; i < 30; i++) send_pressures(SAMPLE_W'($urandom), small_sample());
  endtask

  task automatic test_random_settings();
    int phase;
    int i;
    int pick;
    int level;
    longint r;
    logic signed [SAMPLE_W-1:0] mouth;
    logic signed [SAMPLE_W-1:0] bore;
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        write_setting(CFG_FEEDBACK_ONE, CFG_W'(FB_ONE_RESET));
        write_setting(CFG_FEEDBACK_TWO, CFG_W'(FB_TWO_RESET));
        write_setting(CFG_INPUT_GAIN, CFG_W'(GAIN_RESET));
      end else if (phase % 4 == 3) begin
        write_setting(CFG_FEEDBACK_ONE, CFG_W'($urandom));
        write_setting(CFG_FEEDBACK_TWO, CFG_W'($urandom));
        write_setting(CFG_INPUT_GAIN, CFG_W'($urandom));
      end else begin
        // pole radius between 0.9 and 0.9995, pole angle between 60 and 120 degrees
        r = $urandom_range(58982, 65503);
        write_setting(CFG_FEEDBACK_TWO, CFG_W'(-((r * r) >> 16)));
        write_setting(CFG_FEEDBACK_ONE, CFG_W'(longint'($urandom_range(0, 2 * r)) - r));
        write_setting(CFG_INPUT_GAIN, CFG_W'($urandom_range(0, 12000)));
      end
      gap_max = (phase % 3 == 0) ? 0 : 9;
      stall_max = (phase % 4 == 1) ? 0 : 9;
      level = int'($urandom_range(0, 56000)) - 28000;
      for (i = 0; i < PHASE_BEATS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // steady blowing pressure against a small bore return
          mouth = SAMPLE_W'(level + int'($urandom_range(0, 1023)) - 512);
          bore = small_sample();
        end else if (pick < 85) begin
          mouth = SAMPLE_W'($urandom);
          bore = SAMPLE_W'($urandom);
        end else begin
          mouth = small_sample();
          bore = small_sample();
        end
        send_pressures(mouth, bore);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mouth_sample <= '0;
    in_bore_sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FEEDBACK_ONE;
    cfg_data <= '0;
    fb_one = FB_ONE_RESET;
    fb_two = FB_TWO_RESET;
    gain = GAIN_RESET;
    res_y1 = 0;
    res_y2 = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_extremes();
    test_register_extremes();
    test_output_hold_off();
    test_random_settings();
    settle();
    $display("run covered %0d beats and %0d checked results over %0d register writes",
             beats_sent, results_seen, writes_done);
    $display("including saturated and clamped resonator, ignored index and a long output stall");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
